// ===== rtl/ftfp_pkg.sv =====
// Package for the fixed-timestep frame pacer: payload structs, register
// indexes, reset values and arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ftfp_pkg;

    localparam int TIME_BITS  = 48;
    localparam int STEP_W     = 24;
    localparam int THR_W      = 8;
    localparam int LAG_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int DIV_ITER_W = $clog2(STEP_W);

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS         = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELAPSED_TICKS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LAG_THRESHOLD = CFG_IDX_W'(3);

    localparam logic              RST_FIXED_STEP_MODE = 1'b1;
    localparam logic [STEP_W-1:0] RST_STEP_TICKS      = STEP_W'(166667);
    localparam logic [STEP_W-1:0] RST_MAX_ELAPSED     = STEP_W'(5000000);
    localparam logic [THR_W-1:0]  RST_SLOW_THRESHOLD  = THR_W'(5);

    // 1 ms in 100 ns ticks
    localparam logic [TIME_BITS-1:0] WAIT_MARGIN_TICKS = TIME_BITS'(10000);
    localparam logic [LAG_W-1:0]     LAG_MAX           = '1;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ticks;
        logic                 exit_request;
        logic                 suppress_draw;
    } in_item_t;

    typedef struct packed {
        logic                 waiting;
        logic [STEP_W-1:0]    update_count;
        logic [STEP_W-1:0]    elapsed_ticks;
        logic [TIME_BITS-1:0] total_ticks;
        logic                 running_slowly;
        logic                 draw;
        logic                 stop;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_timestep_frame_pacer.sv =====
// Fixed-timestep frame pacer: sequencer around one shared 24-bit
// shift-subtract unit that counts whole update steps per frame.
// Depends on ftfp_pkg.
//
// Usage: each transaction on s_ (valid/ready) carries a time sample in
// 100 ns ticks plus exit and draw-suppress flags; each one yields exactly
// one result transaction on m_ (valid/ready). The cfg_ channel writes the
// four registers and is always ready; write it only while the block is idle.
// Path from input acceptance to m_valid: DIFF, ACC and CHECK for a "waiting"
// result, then FIN as well in variable mode or when exit is requested, and
// DIV, DIVEND and FIN when steps are counted in fixed mode (DIV is the
// step-count divider, one quotient bit per cycle). s_ready comes back high
// together with m_valid.
// The result sits in an output register: a new sample is accepted while the
// previous result still waits for m_ready. If the receiver stalls, the next
// result waits in its last sequencer state until the register frees up.
// Reset (synchronous, active low) clears accumulator, last sample, game
// total, lag and slow flag, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module fixed_timestep_frame_pacer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ftfp_pkg::in_item_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ftfp_pkg::out_item_t                    m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ftfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ftfp_pkg::STEP_W-1:0]       cfg_data
);
    import ftfp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_DIVEND,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    in_item_t             in_reg, in_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [TIME_BITS-1:0] acc_reg, acc_next;
    logic [TIME_BITS-1:0] total_reg, total_next;
    logic [TIME_BITS-1:0] mag_reg, mag_next;
    logic                 back_reg, back_next;
    logic [LAG_W-1:0]     lag_reg, lag_next;
    logic                 slow_reg, slow_next;
    logic [STEP_W-1:0]    q_reg, q_next;
    logic [STEP_W:0]      rem_reg, rem_next;
    logic [DIV_ITER_W-1:0] iter_reg, iter_next;
    logic [STEP_W-1:0]    elapsed_reg, elapsed_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;

    logic                 mode_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    max_reg;
    logic [THR_W-1:0]     thr_reg;

    logic                 out_free;
    logic [STEP_W-1:0]    step_eff;
    logic [TIME_BITS:0]   acc_sum, acc_dif, gap;
    logic                 below_step, wait_hit, over_max;
    logic [STEP_W-1:0]    acc_clamped;
    logic [STEP_W:0]      div_shift;
    logic [STEP_W+1:0]    div_trial;
    logic [STEP_W:0]      lag_sum;
    logic [LAG_W-1:0]     lag_a, lag_b;
    logic                 slow_a;
    logic [TIME_BITS-1:0] total_sum;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // saturating accumulate, forward or backward
    assign acc_sum = {1'b0, acc_reg} + {1'b0, mag_reg};
    assign acc_dif = {1'b0, acc_reg} - {1'b0, mag_reg};

    assign gap        = {{(TIME_BITS-STEP_W+1){1'b0}}, step_eff} - {1'b0, acc_reg};
    assign below_step = !gap[TIME_BITS] && (gap != '0);
    assign wait_hit   = mode_reg && below_step && (gap[TIME_BITS-1:0] >= WAIT_MARGIN_TICKS);
    assign over_max   = acc_reg > {{(TIME_BITS-STEP_W){1'b0}}, max_reg};
    assign acc_clamped = over_max ? max_reg : acc_reg[STEP_W-1:0];

    // shared restoring-divide step
    assign div_shift = {rem_reg[STEP_W-1:0], q_reg[STEP_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, step_eff};

    // lag bookkeeping on the final step count
    assign lag_sum   = {{(STEP_W+1-LAG_W){1'b0}}, lag_reg} + {1'b0, q_reg} - (STEP_W+1)'(1);
    always_comb begin
        lag_a = lag_reg;
        if (q_reg > STEP_W'(1)) begin
            lag_a = (lag_sum > {{(STEP_W+1-LAG_W){1'b0}}, LAG_MAX}) ? LAG_MAX
                                                                    : lag_sum[LAG_W-1:0];
        end
        if (slow_reg) begin
            slow_a = (lag_a != '0);
        end else begin
            slow_a = (lag_a >= {{(LAG_W-THR_W){1'b0}}, thr_reg});
        end
        lag_b = ((q_reg == STEP_W'(1)) && (lag_a != '0)) ? lag_a - LAG_W'(1) : lag_a;
    end

    assign total_sum = total_reg + {{(TIME_BITS-STEP_W){1'b0}}, elapsed_reg};

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        mag_next     = mag_reg;
        back_next    = back_reg;
        lag_next     = lag_reg;
        slow_next    = slow_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        iter_next    = iter_reg;
        elapsed_next = elapsed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                back_next  = in_reg.now_ticks < last_reg;
                mag_next   = (in_reg.now_ticks < last_reg) ? last_reg - in_reg.now_ticks
                                                           : in_reg.now_ticks - last_reg;
                last_next  = in_reg.now_ticks;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (back_reg) begin
                    acc_next = acc_dif[TIME_BITS] ? '0 : acc_dif[TIME_BITS-1:0];
                end else begin
                    acc_next = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (wait_hit) begin
                    if (out_free) begin
                        m_valid_next                = 1'b1;
                        m_data_next.waiting         = 1'b1;
                        m_data_next.update_count    = '0;
                        m_data_next.elapsed_ticks   = '0;
                        m_data_next.total_ticks     = total_reg;
                        m_data_next.running_slowly  = slow_reg;
                        m_data_next.draw            = 1'b0;
                        m_data_next.stop            = 1'b0;
                        state_next                  = ST_IDLE;
                    end
                end else if (!mode_reg) begin
                    q_next       = STEP_W'(1);
                    elapsed_next = acc_clamped;
                    acc_next     = '0;
                    state_next   = ST_FIN;
                end else if (in_reg.exit_request) begin
                    q_next       = '0;
                    elapsed_next = '0;
                    acc_next     = {{(TIME_BITS-STEP_W){1'b0}}, acc_clamped};
                    state_next   = ST_FIN;
                end else begin
                    q_next     = acc_clamped;
                    rem_next   = '0;
                    iter_next  = '0;
                    acc_next   = {{(TIME_BITS-STEP_W){1'b0}}, acc_clamped};
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_trial[STEP_W+1]) begin
                    rem_next = div_trial[STEP_W:0];
                    q_next   = {q_reg[STEP_W-2:0], 1'b1};
                end else begin
                    rem_next = div_shift;
                    q_next   = {q_reg[STEP_W-2:0], 1'b0};
                end
                iter_next = iter_reg + DIV_ITER_W'(1);
                if (iter_reg == DIV_ITER_W'(STEP_W - 1)) begin
                    state_next = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                // quotient * step is the dividend minus the remainder
                elapsed_next = acc_reg[STEP_W-1:0] - rem_reg[STEP_W-1:0];
                acc_next     = {{(TIME_BITS-STEP_W){1'b0}}, rem_reg[STEP_W-1:0]};
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    total_next = total_sum;
                    if (mode_reg) begin
                        lag_next  = lag_b;
                        slow_next = slow_a;
                    end
                    m_valid_next               = 1'b1;
                    m_data_next.waiting        = 1'b0;
                    m_data_next.update_count   = q_reg;
                    m_data_next.elapsed_ticks  = elapsed_reg;
                    m_data_next.total_ticks    = total_sum;
                    m_data_next.running_slowly = mode_reg ? slow_a : slow_reg;
                    m_data_next.draw           = !in_reg.suppress_draw;
                    m_data_next.stop           = in_reg.exit_request;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            last_reg    <= '0;
            acc_reg     <= '0;
            total_reg   <= '0;
            lag_reg     <= '0;
            slow_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            mode_reg    <= RST_FIXED_STEP_MODE;
            step_reg    <= RST_STEP_TICKS;
            max_reg     <= RST_MAX_ELAPSED;
            thr_reg     <= RST_SLOW_THRESHOLD;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            acc_reg     <= acc_next;
            total_reg   <= total_next;
            lag_reg     <= lag_next;
            slow_reg    <= slow_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FIXED_STEP_MODE:    mode_reg <= cfg_data[0];
                    CFG_STEP_TICKS:         step_reg <= cfg_data;
                    CFG_MAX_ELAPSED_TICKS:  max_reg  <= cfg_data;
                    CFG_SLOW_LAG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        in_reg      <= in_next;
        mag_reg     <= mag_next;
        back_reg    <= back_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        iter_reg    <= iter_next;
        elapsed_reg <= elapsed_next;
        m_data_reg  <= m_data_next;
    end

    // a waiting frame carries no update, draw or stop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.waiting) |->
            (m_data_reg.update_count == '0 && !m_data_reg.draw && !m_data_reg.stop))
        else $error("waiting result carries updates");

    // accumulator already clamped while counting steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (acc_reg <= {{(TIME_BITS-STEP_W){1'b0}}, max_reg}))
        else $error("accumulator above ceiling in divider");

    // partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_DIVEND) |->
            (rem_reg < {1'b0, step_eff}))
        else $error("divider remainder out of range");

    // results are only produced from the check or finish states
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            ($past(state_reg) == ST_CHECK || $past(state_reg) == ST_FIN))
        else $error("result loaded from unexpected state");

endmodule

`default_nettype wire
